[hw/rtl/ets_pkg.sv]
// ----------------------------------------------------------------------------
// ets_pkg
// Shared constants, item types and controller/datapath command types for the
// elapsed time statistics block.
// ----------------------------------------------------------------------------
package ets_pkg;

  localparam int TIME_WIDTH     = 64;
  localparam int COUNT_WIDTH    = 32;
  localparam int MEAN_FRAC_BITS = 16;
  localparam int MEAN_WIDTH     = 48;
  localparam int SQ_FRAC_BITS   = 8;
  localparam int SQ_SHIFT       = 2 * MEAN_FRAC_BITS - SQ_FRAC_BITS;
  localparam int HALF_WIDTH     = MEAN_WIDTH / 2;
  localparam int PROD_WIDTH     = 2 * MEAN_WIDTH;
  localparam int STEP_WIDTH     = $clog2(MEAN_WIDTH);

  localparam logic [63:0] TIME_MASK = 64'((65'(1) << TIME_WIDTH) - 65'(1));
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [MEAN_WIDTH-1:0]  MEAN_MAX  = '1;
  localparam logic [63:0] MEAN_LIMIT = 64'(MEAN_MAX >> MEAN_FRAC_BITS);

  localparam logic [2:0] OP_BEGIN  = 3'd0;
  localparam logic [2:0] OP_END    = 3'd1;
  localparam logic [2:0] OP_SET    = 3'd2;
  localparam logic [2:0] OP_CANCEL = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  typedef struct packed {
    logic [2:0]         op;
    logic [63:0]        timestamp;
    logic signed [63:0] set_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sample_count;
    logic [31:0] overrun_count;
    logic [63:0] total_time;
    logic [63:0] least_time;
    logic [63:0] most_time;
    logic [47:0] mean_time;
    logic [63:0] squared_dev_sum;
    logic        measuring;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       mean_upd;
    logic       mul_step;
    logic       dev_upd;
    logic       emit;
    logic [1:0] mul_idx;
  } cmd_t;

  typedef struct packed {
    logic sample;
  } status_t;

endpackage

[hw/rtl/ets_datapath.sv]
// ----------------------------------------------------------------------------
// ets_datapath
// Statistics registers, restoring divider, split multiplier and the result
// register of the elapsed time statistics block.
// ----------------------------------------------------------------------------
module ets_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ets_pkg::in_item_t  in_data_i,
  input  ets_pkg::cmd_t      cmd_i,
  output ets_pkg::status_t   status_o,
  output ets_pkg::out_item_t out_data_o
);
  import ets_pkg::*;

  logic [TIME_WIDTH-1:0]  start_q, start_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] overrun_q, overrun_d;
  logic [63:0]            sum_q, sum_d;
  logic [63:0]            min_q, min_d;
  logic [63:0]            max_q, max_d;
  logic [MEAN_WIDTH-1:0]  mean_q, mean_d;
  logic [63:0]            dev_q, dev_d;

  logic [MEAN_WIDTH-1:0]  x_q, a_q, b_q, quo_q;
  logic                   up_q;
  logic [COUNT_WIDTH-1:0] rem_q, div_q;
  logic [PROD_WIDTH-1:0]  acc_q;
  out_item_t              out_q;

  logic [TIME_WIDTH-1:0]  ts, diff;
  logic [63:0]            sv_u, d;
  logic                   overrun, sample_ok;
  logic [COUNT_WIDTH-1:0] count_inc, overrun_inc;
  logic [64:0]            sum_wide;
  logic [63:0]            sum_sat;
  logic [MEAN_WIDTH-1:0]  x_new, a_new;
  logic                   up_new;

  // sample classification
  always_comb begin
    ts        = in_data_i.timestamp[TIME_WIDTH-1:0];
    diff      = ts - start_q;
    sv_u      = in_data_i.set_value;
    overrun   = 1'b0;
    sample_ok = 1'b0;
    d         = '0;
    case (in_data_i.op)
      OP_END: begin
        if (start_q != '0) begin
          if (diff[TIME_WIDTH-1]) begin
            overrun = 1'b1;
          end else begin
            sample_ok = 1'b1;
            d         = 64'(diff);
          end
        end
      end
      OP_SET: begin
        if (sv_u[63]) begin
          overrun = 1'b1;
        end else begin
          sample_ok = 1'b1;
          d         = (sv_u > TIME_MASK) ? TIME_MASK : sv_u;
        end
      end
      default: ;
    endcase
  end

  assign status_o.sample = sample_ok;

  always_comb begin
    count_inc   = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_WIDTH'(1);
    overrun_inc = (overrun_q == COUNT_MAX) ? overrun_q : overrun_q + COUNT_WIDTH'(1);
    sum_wide    = 65'(sum_q) + 65'(d);
    sum_sat     = sum_wide[64] ? '1 : sum_wide[63:0];
    x_new       = (d > MEAN_LIMIT) ? MEAN_MAX : MEAN_WIDTH'(d << MEAN_FRAC_BITS);
    up_new      = (x_new >= mean_q);
    a_new       = up_new ? (x_new - mean_q) : (mean_q - x_new);
  end

  // divider step: shift in one dividend bit, subtract when it fits
  logic [COUNT_WIDTH:0]   rem_sh;
  logic                   fits;
  logic [COUNT_WIDTH-1:0] rem_nx;

  always_comb begin
    rem_sh = {rem_q, quo_q[MEAN_WIDTH-1]};
    fits   = (rem_sh >= {1'b0, div_q});
    rem_nx = fits ? COUNT_WIDTH'(rem_sh - {1'b0, div_q}) : rem_sh[COUNT_WIDTH-1:0];
  end

  logic [MEAN_WIDTH-1:0] mean_new, b_new;

  always_comb begin
    mean_new = up_q ? (mean_q + quo_q) : (mean_q - quo_q);
    b_new    = up_q ? (x_q - mean_new) : (mean_new - x_q);
  end

  // one 24 by 24 partial product per cycle
  logic [HALF_WIDTH-1:0]   a_part, b_part;
  logic [2*HALF_WIDTH-1:0] pp;
  logic [PROD_WIDTH-1:0]   pp_ext, pp_sh;
  logic [1:0]              pp_pos;

  always_comb begin
    a_part = cmd_i.mul_idx[1] ? a_q[MEAN_WIDTH-1:HALF_WIDTH] : a_q[HALF_WIDTH-1:0];
    b_part = cmd_i.mul_idx[0] ? b_q[MEAN_WIDTH-1:HALF_WIDTH] : b_q[HALF_WIDTH-1:0];
    pp     = a_part * b_part;
    pp_ext = PROD_WIDTH'(pp);
    pp_pos = {1'b0, cmd_i.mul_idx[1]} + {1'b0, cmd_i.mul_idx[0]};
    case (pp_pos)
      2'd0:    pp_sh = pp_ext;
      2'd1:    pp_sh = pp_ext << HALF_WIDTH;
      default: pp_sh = pp_ext << (2 * HALF_WIDTH);
    endcase
  end

  logic [127:0] prod_sh;
  logic [63:0]  prod_sat;
  logic [64:0]  dev_wide;
  logic [63:0]  dev_sat;

  always_comb begin
    prod_sh  = 128'(acc_q) >> SQ_SHIFT;
    prod_sat = (|prod_sh[127:64]) ? '1 : prod_sh[63:0];
    dev_wide = 65'(dev_q) + 65'(prod_sat);
    dev_sat  = dev_wide[64] ? '1 : dev_wide[63:0];
  end

  always_comb begin
    start_d   = start_q;
    count_d   = count_q;
    overrun_d = overrun_q;
    sum_d     = sum_q;
    min_d     = min_q;
    max_d     = max_q;
    mean_d    = mean_q;
    dev_d     = dev_q;
    if (cmd_i.load) begin
      case (in_data_i.op)
        OP_BEGIN: start_d = ts;
        OP_END, OP_SET: begin
          if (overrun) begin
            overrun_d = overrun_inc;
          end
          if (sample_ok) begin
            count_d = count_inc;
            sum_d   = sum_sat;
            start_d = '0;
            if (min_q == '0 || d < min_q) begin
              min_d = d;
            end
            if (d > max_q) begin
              max_d = d;
            end
          end
        end
        OP_CANCEL: start_d = '0;
        OP_CLEAR: begin
          start_d = '0;
          count_d = '0;
          sum_d   = '0;
          min_d   = '0;
          max_d   = '0;
          mean_d  = '0;
          dev_d   = '0;
        end
        default: ;
      endcase
    end
    if (cmd_i.mean_upd) begin
      mean_d = mean_new;
    end
    if (cmd_i.dev_upd) begin
      dev_d = dev_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= '0;
      count_q   <= '0;
      overrun_q <= '0;
      sum_q     <= '0;
      min_q     <= '0;
      max_q     <= '0;
      mean_q    <= '0;
      dev_q     <= '0;
    end else begin
      start_q   <= start_d;
      count_q   <= count_d;
      overrun_q <= overrun_d;
      sum_q     <= sum_d;
      min_q     <= min_d;
      max_q     <= max_d;
      mean_q    <= mean_d;
      dev_q     <= dev_d;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= x_new;
      up_q  <= up_new;
      a_q   <= a_new;
      quo_q <= a_new;
      rem_q <= '0;
      div_q <= count_inc;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[MEAN_WIDTH-2:0], fits};
    end
    if (cmd_i.mean_upd) begin
      b_q   <= b_new;
      acc_q <= '0;
    end
    if (cmd_i.mul_step) begin
      acc_q <= acc_q + pp_sh;
    end
    if (cmd_i.emit) begin
      out_q.sample_count    <= 32'(count_q);
      out_q.overrun_count   <= 32'(overrun_q);
      out_q.total_time      <= sum_q;
      out_q.least_time      <= min_q;
      out_q.most_time       <= max_q;
      out_q.mean_time       <= mean_q;
      out_q.squared_dev_sum <= dev_q;
      out_q.measuring       <= (start_q != '0);
    end
  end

  assign out_data_o = out_q;

  // remainder of the divider stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> rem_q < div_q)
    else $error("divider remainder not below divisor");

  // mean moves towards the sample and never past it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mean_upd && up_q) |=> mean_q <= x_q)
    else $error("rising mean overshoots sample");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mean_upd && !up_q) |=> mean_q >= x_q)
    else $error("falling mean overshoots sample");

endmodule

[hw/rtl/ets_controller.sv]
// ----------------------------------------------------------------------------
// ets_controller
// Sequencer for the elapsed time statistics block: takes an item, walks the
// divider and multiplier for a sample, and hands the snapshot to the output register.
// ----------------------------------------------------------------------------
module ets_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  ets_pkg::status_t status_i,
  output ets_pkg::cmd_t    cmd_o
);
  import ets_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DIVIDE   = 6'b000010,
    S_UPDATE   = 6'b000100,
    S_MULTIPLY = 6'b001000,
    S_COMMIT   = 6'b010000,
    S_EMIT     = 6'b100000
  } state_e;

  localparam logic [STEP_WIDTH-1:0] DIV_LAST = STEP_WIDTH'(MEAN_WIDTH - 1);

  state_e                state_q, state_d;
  logic [STEP_WIDTH-1:0] cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.mul_idx = cnt_q[1:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = status_i.sample ? S_DIVIDE : S_EMIT;
        end
      end
      S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          state_d = S_UPDATE;
        end else begin
          cnt_d = cnt_q + STEP_WIDTH'(1);
        end
      end
      S_UPDATE: begin
        cmd_o.mean_upd = 1'b1;
        state_d        = S_MULTIPLY;
      end
      S_MULTIPLY: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q[1:0] == 2'b11) begin
          cnt_d   = '0;
          state_d = S_COMMIT;
        end else begin
          cnt_d = cnt_q + STEP_WIDTH'(1);
        end
      end
      S_COMMIT: begin
        cmd_o.dev_upd = 1'b1;
        state_d       = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.div_step, cmd_o.mean_upd,
              cmd_o.mul_step, cmd_o.dev_upd, cmd_o.emit}))
    else $error("more than one datapath command at once");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVIDE && cnt_q == DIV_LAST) |=> state_q == S_UPDATE)
    else $error("divide did not end after its last step");

  // items with no sample go straight to the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !status_i.sample) |=> state_q == S_EMIT)
    else $error("non-sample transfer did not go to emit");

endmodule

[hw/rtl/elapsed_time_statistics.sv]
// ----------------------------------------------------------------------------
// elapsed_time_statistics
// Latency monitor keeping count, total, min, max and running mean/variance.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o / in_data_i) carries one operation:
//   begin, end, set duration, cancel or clear. every transfer produces exactly
//   one snapshot on the output channel (out_valid_o / out_stall_i /
//   out_data_o), taken after the item has updated the statistics.
//   begin, cancel, clear, overruns and ends with nothing open go from the load
//   step straight to the emit step. an accepted sample walks these steps in
//   order: load, the bit-per-cycle divide of the mean step by the count, mean
//   update, the 24x24 partial products of the deviation term, commit and the
//   load of the output register. one item is worked at a time: no new input is
//   taken until its snapshot is loaded; input is taken again the cycle after
//   the snapshot is loaded, even while it still waits downstream.
//   a stalled receiver holds the snapshot; a finished item waits in the emit
//   step until the output register is free. reset clears all statistics and
//   closes any open measurement; no output is valid after reset.
// ----------------------------------------------------------------------------
module elapsed_time_statistics (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ets_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ets_pkg::out_item_t out_data_o
);
  import ets_pkg::*;

  cmd_t    cmd;
  status_t status;

  ets_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ets_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

[tb/elapsed_time_statistics_test.sv]
// ----------------------------------------------------------------------------
// elapsed_time_statistics_test
// Self-checking bench for the latency statistics monitor. Directed items hit
// wrap-around, overrun, saturation and idle-op cases, then random begin/end,
// set, cancel, clear and spare-op items run with random input gaps and output
// stalls. Each snapshot is checked per field against a bit-true running model.
// ----------------------------------------------------------------------------
module elapsed_time_statistics_test;

  timeunit 1ns;
  timeprecision 1ps;

  import ets_pkg::*;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam int ITEM_TARGET   = 1250;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int LONG_HOLD     = 1500;
  localparam int HOLD_AT_COUNT = 400;
  localparam int PAUSE_AT_ITEM = 700;
  localparam int DRAIN_CYCLES  = 200;

  // running statistics model with a queue of predicted snapshots
  class stats_tracker;
    logic [TIME_WIDTH-1:0]  open_start;
    logic [COUNT_WIDTH-1:0] n_samples;
    logic [COUNT_WIDTH-1:0] n_overruns;
    logic [63:0]            sum_us;
    logic [63:0]            min_us;
    logic [63:0]            max_us;
    logic [MEAN_WIDTH-1:0]  mean_fx;
    logic [63:0]            dev_fx;
    out_item_t              snapshot_q[$];
    int op_seen[8];
    int n_taken;
    int n_overrun_events;
    int n_ignored;
    int n_checked;
    int n_mismatch;

    function new();
      open_start = '0;
      n_samples  = '0;
      n_overruns = '0;
      sum_us     = '0;
      min_us     = '0;
      max_us     = '0;
      mean_fx    = '0;
      dev_fx     = '0;
      foreach (op_seen[k]) op_seen[k] = 0;
      n_taken = 0;
      n_overrun_events = 0;
      n_ignored = 0;
      n_checked = 0;
      n_mismatch = 0;
    endfunction

    function logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    function void bump_overrun();
      if (n_overruns != COUNT_MAX) n_overruns = n_overruns + 1'b1;
      n_overrun_events++;
    endfunction

    function void take_duration(logic [63:0] d);
      logic [MEAN_WIDTH-1:0] x, a, b, q, m_new;
      logic                  up;
      logic [95:0]           prod;
      logic [95:0]           shifted;
      if (n_samples != COUNT_MAX) n_samples = n_samples + 1'b1;
      sum_us = sat_add64(sum_us, d);
      if (min_us == '0 || d < min_us) min_us = d;
      if (d > max_us) max_us = d;
      // welford step in fixed point, magnitude and direction kept apart
      x = (d > MEAN_LIMIT) ? MEAN_MAX : MEAN_WIDTH'(d << MEAN_FRAC_BITS);
      up = (x >= mean_fx);
      a = up ? (x - mean_fx) : (mean_fx - x);
      q = MEAN_WIDTH'(a / n_samples);
      m_new = up ? (mean_fx + q) : (mean_fx - q);
      b = up ? (x - m_new) : (m_new - x);
      mean_fx = m_new;
      prod = 96'(a) * 96'(b);
      shifted = prod >> SQ_SHIFT;
      dev_fx = sat_add64(dev_fx, (shifted[95:64] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                       : shifted[63:0]);
      n_taken++;
    endfunction

    function void note_item(in_item_t it);
      logic [63:0] ts;
      logic [63:0] sv;
      logic [63:0] diff;
      out_item_t   snap;
      ts = it.timestamp & TIME_MASK;
      sv = $unsigned(it.set_value);
      op_seen[it.op]++;
      case (it.op)
        OP_BEGIN: begin
          open_start = ts;
        end
        OP_END: begin
          if (open_start != '0) begin
            diff = (ts - open_start) & TIME_MASK;
            if (diff[TIME_WIDTH-1]) begin
              bump_overrun();
            end else begin
              take_duration(diff);
              open_start = '0;
            end
          end else begin
            n_ignored++;
          end
        end
        OP_SET: begin
          if (sv[63]) begin
            bump_overrun();
          end else begin
            take_duration((sv > TIME_MASK) ? TIME_MASK : sv);
            open_start = '0;
          end
        end
        OP_CANCEL: begin
          open_start = '0;
        end
        OP_CLEAR: begin
          // overrun count survives a clear
          open_start = '0;
          n_samples  = '0;
          sum_us     = '0;
          min_us     = '0;
          max_us     = '0;
          mean_fx    = '0;
          dev_fx     = '0;
        end
        default: begin
          n_ignored++;
        end
      endcase
      snap.sample_count    = 32'(n_samples);
      snap.overrun_count   = 32'(n_overruns);
      snap.total_time      = sum_us;
      snap.least_time      = min_us;
      snap.most_time       = max_us;
      snap.mean_time       = mean_fx;
      snap.squared_dev_sum = dev_fx;
      snap.measuring       = (open_start != '0);
      snapshot_q.push_back(snap);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("snapshot %0d: %s expected %h got %h", n_checked, name, want, got);
      end
    endfunction

    function void check_snapshot(out_item_t got);
      out_item_t want;
      if (snapshot_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected snapshot transfer: %h", got);
        return;
      end
      want = snapshot_q.pop_front();
      compare_field("sample_count", 64'(want.sample_count), 64'(got.sample_count));
      compare_field("overrun_count", 64'(want.overrun_count), 64'(got.overrun_count));
      compare_field("total_time", want.total_time, got.total_time);
      compare_field("least_time", want.least_time, got.least_time);
      compare_field("most_time", want.most_time, got.most_time);
      compare_field("mean_time", 64'(want.mean_time), 64'(got.mean_time));
      compare_field("squared_dev_sum", want.squared_dev_sum, got.squared_dev_sum);
      compare_field("measuring", 64'(want.measuring), 64'(got.measuring));
      n_checked++;
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  stats_tracker tracker = new();
  int n_sent        = 0;
  int n_cycles      = 0;
  int tx_quiet_left = 0;

  elapsed_time_statistics dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d snapshots outstanding",
               n_cycles, tracker.snapshot_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t pack_op(logic [2:0] op, logic [63:0] ts, logic [63:0] sv);
    in_item_t it;
    it.op        = op;
    it.timestamp = ts;
    it.set_value = sv;
    return it;
  endfunction

  // mostly short gaps, a few long ones, and runs of back-to-back transfers
  function automatic int next_gap();
    int r;
    if (tx_quiet_left > 0) begin
      tx_quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 10) begin
      tx_quiet_left = $urandom_range(30, 100);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  task automatic send_item(input in_item_t it, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    tracker.note_item(it);
    n_sent++;
  endtask

  // receiving side: checks at the rising edge, changes stall at the falling edge
  initial begin : drain
    int  hold_left;
    int  run_left;
    bit  stalling;
    bit  long_hold_done;
    int  r;
    hold_left = 0;
    run_left = 0;
    stalling = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid && !out_stall) tracker.check_snapshot(out_data);
      @(negedge clk_i);
      if (!long_hold_done && tracker.n_checked >= HOLD_AT_COUNT) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 50) begin
            stalling = 1'b0;
            run_left = $urandom_range(1, 8);
          end else if (r < 65) begin
            stalling = 1'b0;
            run_left = $urandom_range(50, 300);
          end else if (r < 95) begin
            stalling = 1'b1;
            run_left = $urandom_range(1, 4);
          end else begin
            stalling = 1'b1;
            run_left = $urandom_range(20, 100);
          end
        end
        run_left--;
        out_stall <= stalling;
      end
    end
  end

  initial begin : stimulus
    logic [63:0] t0;
    logic [63:0] d;
    logic [63:0] sv;
    int          r;
    bit          pause_done;
    pause_done = 1'b0;
    wait (rst_ni);

    // directed corner cases
    send_item(pack_op(OP_END, rand64(), rand64()), next_gap());
    send_item(pack_op(OP_BEGIN, 64'd0, 64'd0), next_gap());
    send_item(pack_op(OP_END, 64'd55, 64'd0), next_gap());
    send_item(pack_op(OP_BEGIN, 64'd1000, 64'd0), next_gap());
    send_item(pack_op(OP_END, 64'd500, 64'd0), next_gap());         // goes backwards
    send_item(pack_op(OP_END, 64'd1000, 64'd0), next_gap());        // zero duration
    send_item(pack_op(OP_BEGIN, '1, '1), next_gap());
    send_item(pack_op(OP_END, 64'd5, 64'd0), next_gap());           // wraps past zero
    send_item(pack_op(OP_SET, '0, 64'd0), next_gap());
    send_item(pack_op(OP_SET, '0, '1), next_gap());
    send_item(pack_op(OP_SET, '1, 64'h8000_0000_0000_0000), next_gap());
    send_item(pack_op(OP_SET, '0, MEAN_LIMIT), next_gap());
    send_item(pack_op(OP_SET, '0, MEAN_LIMIT + 64'd1), next_gap());
    repeat (3) send_item(pack_op(OP_SET, '0, 64'h7FFF_FFFF_FFFF_FFFF), next_gap());
    send_item(pack_op(OP_SET, '0, 64'd1), next_gap());
    send_item(pack_op(OP_BEGIN, 64'd7, 64'd0), next_gap());
    send_item(pack_op(OP_CANCEL, '1, '1), next_gap());
    send_item(pack_op(OP_BEGIN, 64'd300, 64'd0), next_gap());
    for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
      send_item(pack_op(3'(k), rand64(), rand64()), next_gap());
    send_item(pack_op(OP_SET, 64'd0, 64'd10), next_gap());          // closes open one
    send_item(pack_op(OP_CLEAR, rand64(), rand64()), next_gap());
    send_item(pack_op(OP_SET, '0, 64'd42), next_gap());

    // random traffic, mostly well-formed measurements
    while (n_sent < ITEM_TARGET) begin
      if (!pause_done && n_sent >= PAUSE_AT_ITEM) begin
        pause_done = 1'b1;
        @(negedge clk_i);
        in_valid <= 1'b0;
        while (tracker.snapshot_q.size() != 0) @(posedge clk_i);
      end
      r = $urandom_range(0, 99);
      t0 = ($urandom_range(0, 49) == 0) ? 64'd0 : rand64();
      if (r < 50) begin
        send_item(pack_op(OP_BEGIN, t0, rand64()), next_gap());
        case ($urandom_range(0, 19))
          0, 1:    d = {32'd0, $urandom};
          2:       d = -64'($urandom_range(1, 1000));
          3:       d = rand64() >> 1;
          default: d = 64'($urandom_range(0, 5000));
        endcase
        send_item(pack_op(OP_END, t0 + d, rand64()), next_gap());
        if (d[63])
          send_item(pack_op(OP_END, t0 + 64'($urandom_range(0, 5000)), rand64()),
                    next_gap());
      end else if (r < 75) begin
        if (r >= 70) send_item(pack_op(OP_BEGIN, t0, rand64()), next_gap());
        case ($urandom_range(0, 9))
          0:       sv = MEAN_LIMIT - 64'd2 + 64'($urandom_range(0, 4));
          1:       sv = rand64() | 64'h8000_0000_0000_0000;
          2:       sv = rand64();
          default: sv = 64'($urandom_range(0, 100000));
        endcase
        send_item(pack_op(OP_SET, rand64(), sv), next_gap());
      end else if (r < 82) begin
        send_item(pack_op(OP_BEGIN, t0, rand64()), next_gap());
        send_item(pack_op(OP_CANCEL, rand64(), rand64()), next_gap());
        send_item(pack_op(OP_END, t0 + 64'($urandom_range(0, 5000)), rand64()),
                  next_gap());
      end else if (r < 87) begin
        send_item(pack_op(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                          rand64(), rand64()), next_gap());
      end else if (r < 90) begin
        send_item(pack_op(OP_CLEAR, rand64(), rand64()), next_gap());
      end else begin
        send_item(pack_op(3'($urandom_range(0, 7)), rand64(), rand64()), next_gap());
      end
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    while (tracker.snapshot_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.snapshot_q.size() != 0) tracker.n_mismatch++;

    $display("%0d transfers in: begin %0d, end %0d, set %0d, cancel %0d, clear %0d, other %0d",
             n_sent, tracker.op_seen[OP_BEGIN], tracker.op_seen[OP_END],
             tracker.op_seen[OP_SET], tracker.op_seen[OP_CANCEL], tracker.op_seen[OP_CLEAR],
             tracker.op_seen[OP_SPARE_FIRST] + tracker.op_seen[OP_SPARE_FIRST + 3'd1]
               + tracker.op_seen[OP_SPARE_LAST]);
    $display("%0d samples taken, %0d overruns, %0d with no effect, %0d snapshots checked, %0d mismatches",
             tracker.n_taken, tracker.n_overrun_events, tracker.n_ignored,
             tracker.n_checked, tracker.n_mismatch);
    if (tracker.n_mismatch == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[elapsed_time_statistics.f]
hw/rtl/ets_pkg.sv
hw/rtl/ets_datapath.sv
hw/rtl/ets_controller.sv
hw/rtl/elapsed_time_statistics.sv
tb/elapsed_time_statistics_test.sv
